// ===== hdl/rdu_pkg.sv =====
// Shared types, constants and digit functions for the radix digit unpacker.
package rdu_pkg;

    localparam int DIGIT_W  = 3;
    localparam int MAX_DIGS = 6;
    localparam int CNT_W    = 3;

    // mode register codes
    localparam logic [1:0] MODE_QUIN = 2'd1;
    localparam logic [1:0] MODE_OCT  = 2'd2;

    // register index decoded from paddr[2]
    localparam logic REG_MODE = 1'b0;

    // last position within a group
    localparam logic [2:0] QUIN_GROUP_LAST = 3'd6;
    localparam logic [2:0] OCT_GROUP_LAST  = 3'd2;

    typedef logic [DIGIT_W-1:0] t_digit;

    typedef enum logic [1:0] {
        KIND_TRIT = 2'd0,
        KIND_QUIN = 2'd1,
        KIND_OCT  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte_val;
        logic [6:0] side_val;
        logic       grp_done;
    } t_job;

    // floor(v/3) for v < 256
    function automatic logic [7:0] div3(input logic [7:0] v);
        logic [16:0] p;
        p = {9'd0, v} * 17'd171;
        return p[16:9];
    endfunction

    // floor(v/9) for v < 256
    function automatic logic [7:0] div9(input logic [7:0] v);
        logic [16:0] p;
        p = {9'd0, v} * 17'd57;
        return p[16:9];
    endfunction

    // floor(v/27) for v < 256
    function automatic logic [7:0] div27(input logic [7:0] v);
        logic [16:0] p;
        p = {9'd0, v} * 17'd19;
        return p[16:9];
    endfunction

    // floor(v/81) for v < 256
    function automatic logic [7:0] div81(input logic [7:0] v);
        logic [21:0] p;
        p = {14'd0, v} * 22'd203;
        return p[21:14];
    endfunction

    // floor(v/5) for v < 128
    function automatic logic [6:0] div5(input logic [6:0] v);
        logic [14:0] p;
        p = {8'd0, v} * 15'd205;
        return {2'd0, p[14:10]};
    endfunction

    // floor(v/25) for v < 128
    function automatic logic [6:0] div25(input logic [6:0] v);
        logic [15:0] p;
        p = {9'd0, v} * 16'd41;
        return {1'd0, p[15:10]};
    endfunction

    // five base-3 digits, most significant in the top slice, top one wrapped;
    // every quotient comes straight from v so the digits settle in parallel
    function automatic logic [14:0] trit5(input logic [7:0] v);
        logic [7:0] q1, q2, q3, q4;
        logic [7:0] r1, r2, r3, r4;
        logic [2:0] top;
        q1 = div3(v);
        q2 = div9(v);
        q3 = div27(v);
        q4 = div81(v);
        r4 = v - q1 * 8'd3;
        r3 = q1 - q2 * 8'd3;
        r2 = q2 - q3 * 8'd3;
        r1 = q3 - q4 * 8'd3;
        top = (q4[2:0] == 3'd3) ? 3'd0 : q4[2:0];
        return {top, r1[2:0], r2[2:0], r3[2:0], r4[2:0]};
    endfunction

    // three base-5 digits, top one wrapped
    function automatic logic [8:0] quin3(input logic [6:0] v);
        logic [6:0] q1, q2;
        logic [6:0] r1, r2;
        logic [2:0] top;
        q1 = div5(v);
        r2 = v - q1 * 7'd5;
        q2 = div25(v);
        r1 = q1 - q2 * 7'd5;
        top = (q2[2:0] >= 3'd5) ? q2[2:0] - 3'd5 : q2[2:0];
        return {top, r1[2:0], r2[2:0]};
    endfunction

endpackage

// ===== hdl/rdu_front.sv =====
// Front end: takes input beats, tracks group position and side bits, issues jobs.
module rdu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_mode,
    input  logic          i_valid,
    input  logic [7:0]    i_packed_byte,
    input  logic          i_stream_end,
    output logic          o_stall,
    input  logic          i_q_full,
    output logic          o_push,
    output rdu_pkg::t_job o_job
);
    import rdu_pkg::*;

    logic [2:0] r_grp_pos, n_grp_pos;
    logic [6:0] r_side, n_side;
    logic       accept;
    t_kind      kind;
    logic [6:0] side_upd;
    logic       done;

    assign o_stall = i_q_full;
    assign accept  = i_valid & ~i_q_full;
    assign o_push  = accept;

    always_comb begin
        case (i_mode)
            MODE_QUIN: kind = KIND_QUIN;
            MODE_OCT:  kind = KIND_OCT;
            default:   kind = KIND_TRIT;
        endcase
    end

    always_comb begin
        side_upd  = r_side;
        done      = 1'b0;
        n_grp_pos = r_grp_pos;
        n_side    = r_side;
        case (kind)
            KIND_QUIN: begin
                side_upd = {i_packed_byte[0], r_side[6:1]};
                done     = (r_grp_pos >= QUIN_GROUP_LAST);
            end
            KIND_OCT: begin
                side_upd = {1'b0, i_packed_byte[1:0], r_side[5:2]};
                done     = (r_grp_pos >= OCT_GROUP_LAST);
            end
            default: begin
                side_upd = r_side;
                done     = 1'b0;
            end
        endcase
        if (kind != KIND_TRIT) begin
            if (done) begin
                n_grp_pos = '0;
                n_side    = '0;
            end else begin
                n_grp_pos = r_grp_pos + 3'd1;
                n_side    = side_upd;
            end
        end
        // stream end drops any partial group
        if (i_stream_end) begin
            n_grp_pos = '0;
            n_side    = '0;
        end
    end

    assign o_job.kind     = kind;
    assign o_job.byte_val = i_packed_byte;
    assign o_job.side_val = side_upd;
    assign o_job.grp_done = done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_pos <= '0;
            r_side    <= '0;
        end else if (accept) begin
            r_grp_pos <= n_grp_pos;
            r_side    <= n_side;
        end
    end

endmodule

// ===== hdl/rdu_queue.sv =====
// Small job queue between the front and back ends.
module rdu_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rdu_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output rdu_pkg::t_job o_job
);
    import rdu_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

    t_job              mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_job   = mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_QW'(1);
                2'b01:   r_count <= r_count - CNT_QW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/rdu_back.sv =====
// Back end: expands a job into its digits and shifts them out one beat at a time.
module rdu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  rdu_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [2:0]    o_digit,
    output logic          o_run_last
);
    import rdu_pkg::*;

    t_digit           r_dig [MAX_DIGS];
    t_digit           n_dig [MAX_DIGS];
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_digit           ld_dig [MAX_DIGS];
    logic [CNT_W-1:0] ld_cnt;
    logic [14:0]      trits;
    logic [8:0]       quin_main, quin_side;
    logic             out_fire, can_load, load;

    assign o_valid    = (r_cnt != '0);
    assign o_digit    = r_dig[0];
    assign o_run_last = (r_cnt == CNT_W'(1));
    assign out_fire   = o_valid & ~i_stall;
    assign can_load   = (r_cnt == '0) | ((r_cnt == CNT_W'(1)) & out_fire);
    assign load       = can_load & i_job_valid;
    assign o_pop      = load;

    assign trits     = trit5(i_job.byte_val);
    assign quin_main = quin3(i_job.byte_val[7:1]);
    assign quin_side = quin3(i_job.side_val);

    // digit list, most significant first in slot 0
    always_comb begin
        for (int i = 0; i < MAX_DIGS; i++) begin
            ld_dig[i] = '0;
        end
        case (i_job.kind)
            KIND_QUIN: begin
                ld_dig[0] = quin_main[8:6];
                ld_dig[1] = quin_main[5:3];
                ld_dig[2] = quin_main[2:0];
                ld_dig[3] = quin_side[8:6];
                ld_dig[4] = quin_side[5:3];
                ld_dig[5] = quin_side[2:0];
                ld_cnt    = i_job.grp_done ? CNT_W'(6) : CNT_W'(3);
            end
            KIND_OCT: begin
                ld_dig[0] = i_job.byte_val[7:5];
                ld_dig[1] = i_job.byte_val[4:2];
                ld_dig[2] = i_job.side_val[5:3];
                ld_dig[3] = i_job.side_val[2:0];
                ld_cnt    = i_job.grp_done ? CNT_W'(4) : CNT_W'(2);
            end
            default: begin
                ld_dig[0] = trits[14:12];
                ld_dig[1] = trits[11:9];
                ld_dig[2] = trits[8:6];
                ld_dig[3] = trits[5:3];
                ld_dig[4] = trits[2:0];
                ld_cnt    = CNT_W'(5);
            end
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        for (int i = 0; i < MAX_DIGS; i++) begin
            n_dig[i] = r_dig[i];
        end
        if (load) begin
            n_cnt = ld_cnt;
            for (int i = 0; i < MAX_DIGS; i++) begin
                n_dig[i] = ld_dig[i];
            end
        end else if (out_fire) begin
            n_cnt = r_cnt - CNT_W'(1);
            for (int i = 0; i < MAX_DIGS - 1; i++) begin
                n_dig[i] = r_dig[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_DIGS; i++) begin
            r_dig[i] <= n_dig[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== hdl/radix_digit_unpacker.sv =====
// Radix digit unpacker top level: mode register, front end, job queue and back end.
// Path: a taken beat is written into the job queue, then loaded into the output shift register,
// from which its first digit is presented; an empty output register takes the job at once.
// Throughput: one digit per cycle on the output while i_stall is low; a byte yields 2 to 6 digits,
// the output shift register being the limit; the queue lets the next byte enter meanwhile.
// Reset (synchronous, active low) clears mode to 0, group state, queue and output.
module radix_digit_unpacker #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_packed_byte,
    input  logic        i_stream_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_digit,
    output logic        o_run_last
);
    import rdu_pkg::*;

    logic [1:0] r_mode;
    logic       cfg_wr;
    logic       push, q_full, pop, q_valid;
    t_job       fr_job, q_job;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_MODE);
    assign prdata = (paddr[2] == REG_MODE) ? {30'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
        end else if (cfg_wr) begin
            r_mode <= pwdata[1:0];
        end
    end

    rdu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (r_mode),
        .i_valid       (i_valid),
        .i_packed_byte (i_packed_byte),
        .i_stream_end  (i_stream_end),
        .o_stall       (o_stall),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (fr_job)
    );

    rdu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (fr_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    rdu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(q_valid),
        .i_job      (q_job),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_digit    (o_digit),
        .o_run_last (o_run_last)
    );

endmodule
